/* hdl/xyma_pkg.sv */
package xyma_pkg;

    // field widths
    localparam int DATA_W  = 10;
    localparam int OUT_W   = 11;
    localparam int CNT_W   = 8;
    localparam int LIMIT_W = 8;

    localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};
    localparam logic [OUT_W-1:0] OUT_MINUS_ONE = {OUT_W{1'b1}};

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_CNT_LIMIT = 2'd2;

    localparam logic [DATA_W-1:0]  JUMP_LIMIT_RST  = 10'd20;
    localparam logic [LIMIT_W-1:0] STILL_LIMIT_RST = 8'd10;

    // pipeline control shared by the lanes and the gate
    typedef struct packed {
        logic load;     // item taken into stage one, state updates
        logic advance;  // stage one item moves to the output register
    } pipe_ctrl_t;

endpackage

/* hdl/xyma_lane.sv */
module xyma_lane #(
    parameter int WINDOW = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  xyma_pkg::pipe_ctrl_t         ctrl,
    input  logic [xyma_pkg::DATA_W-1:0]  sample,
    input  logic [xyma_pkg::DATA_W-1:0]  jump_limit,
    output logic                         jump,
    output logic [xyma_pkg::DATA_W-1:0]  mean
);
    import xyma_pkg::*;

    localparam int LOG_W   = $clog2(WINDOW);
    localparam int SUM_W   = DATA_W + LOG_W;
    localparam int SHIFT   = SUM_W + LOG_W;
    localparam int RECIP_W = SHIFT;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // ceil(2^SHIFT / WINDOW), exact floor for any sum below 2^SUM_W
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << SHIFT) + WINDOW - 1) / WINDOW);

    logic [DATA_W-1:0] win_reg  [WINDOW];
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [DATA_W-1:0] diff;
    logic [PROD_W-1:0] prod;
    logic [DATA_W-1:0] mean_reg;

    // jump test against the newest stored sample
    always_comb
    begin
        if (sample >= win_reg[WINDOW-1])
        begin
            diff = sample - win_reg[WINDOW-1];
        end
        else
        begin
            diff = win_reg[WINDOW-1] - sample;
        end
    end

    assign jump = (diff > jump_limit);

    // running sum: add the new sample, drop the oldest
    assign sum_next = sum_reg + SUM_W'(sample) - SUM_W'(win_reg[0]);

    // window shift line and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else if (ctrl.load)
        begin
            for (int i = 0; i < WINDOW - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WINDOW-1] <= sample;
            sum_reg           <= sum_next;
        end
    end

    // mean by reciprocal multiply, registered into the output stage
    assign prod = PROD_W'(sum_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            mean_reg <= prod[SHIFT +: DATA_W];
        end
    end

    assign mean = mean_reg;

endmodule

/* hdl/xyma_gate.sv */
module xyma_gate (
    input  logic                          clk,
    input  logic                          rst_n,
    input  xyma_pkg::pipe_ctrl_t          ctrl,
    input  logic                          jump_x,
    input  logic                          jump_y,
    input  logic [xyma_pkg::LIMIT_W-1:0]  still_limit,
    output logic                          gate
);
    import xyma_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             s1_gate_next;
    logic             s1_gate_reg;
    logic             out_gate_reg;

    // stillness counter merges the two lane jump flags
    always_comb
    begin
        if (jump_x && jump_y)
        begin
            cnt_next     = '0;
            s1_gate_next = 1'b0;
        end
        else
        begin
            cnt_next     = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
            s1_gate_next = (cnt_next >= still_limit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.load)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // gate flag follows its item down the pipe
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            s1_gate_reg <= s1_gate_next;
        end
        if (ctrl.advance)
        begin
            out_gate_reg <= s1_gate_reg;
        end
    end

    assign gate = out_gate_reg;

endmodule

/* hdl/xy_moving_average_motion_gate_core.sv */
// Moving-average filter for x,y touch samples with a stillness gate. Each item
// carries one sample pair; each axis lane keeps the last WINDOW samples (zero
// after reset) in a shift line with a running sum, and the result item gives
// the floor of each window mean, or -1 on both axes once the count of samples
// without a two-axis jump reaches still_count_limit. One item is taken every
// cycle unless result_stall keeps both stages full; the accepting edge loads
// stage one with window, sum and counter, then the reciprocal multiply fills
// the output register, which offers the result. Configuration writes are
// always ready and must only happen while no item is in flight.
module xy_moving_average_motion_gate_core #(
    parameter int WINDOW = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic [xyma_pkg::DATA_W-1:0]          x_sample,
    input  logic [xyma_pkg::DATA_W-1:0]          y_sample,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [xyma_pkg::OUT_W-1:0]    x_filtered,
    output logic signed [xyma_pkg::OUT_W-1:0]    y_filtered,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [xyma_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [xyma_pkg::DATA_W-1:0]          cfg_data
);
    import xyma_pkg::*;

    logic [DATA_W-1:0]  jump_limit_x_reg;
    logic [DATA_W-1:0]  jump_limit_y_reg;
    logic [LIMIT_W-1:0] still_limit_reg;

    logic       s1_valid_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       s1_free;
    pipe_ctrl_t ctrl;

    logic              jump_x;
    logic              jump_y;
    logic [DATA_W-1:0] mean_x;
    logic [DATA_W-1:0] mean_y;
    logic              gate;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_limit_x_reg <= JUMP_LIMIT_RST;
            jump_limit_y_reg <= JUMP_LIMIT_RST;
            still_limit_reg  <= STILL_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_JUMP_LIMIT_X:    jump_limit_x_reg <= cfg_data;
                CFG_JUMP_LIMIT_Y:    jump_limit_y_reg <= cfg_data;
                CFG_STILL_CNT_LIMIT: still_limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:             ;
            endcase
        end
    end

    // two-stage pipe flow control
    assign out_free     = !out_valid_reg || !result_stall;
    assign s1_free      = !s1_valid_reg || out_free;
    assign sample_stall = !s1_free;

    always_comb
    begin
        ctrl.load    = sample_valid && s1_free;
        ctrl.advance = s1_valid_reg && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // axis lanes
    xyma_lane #(
        .WINDOW     (WINDOW)
    ) u_lane_x (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .sample     (x_sample),
        .jump_limit (jump_limit_x_reg),
        .jump       (jump_x),
        .mean       (mean_x)
    );

    xyma_lane #(
        .WINDOW     (WINDOW)
    ) u_lane_y (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .sample     (y_sample),
        .jump_limit (jump_limit_y_reg),
        .jump       (jump_y),
        .mean       (mean_y)
    );

    // merge of lane jump flags into the stillness gate
    xyma_gate u_gate (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .jump_x      (jump_x),
        .jump_y      (jump_y),
        .still_limit (still_limit_reg),
        .gate        (gate)
    );

    // result item
    assign result_valid = out_valid_reg;
    assign x_filtered   = gate ? OUT_MINUS_ONE : {1'b0, mean_x};
    assign y_filtered   = gate ? OUT_MINUS_ONE : {1'b0, mean_y};

    // stall only when both stages hold items
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // a held stage one item is not lost
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("stage one item dropped while output blocked");

    // the gate acts on both axes together
    a_gate_both: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && x_filtered == OUT_MINUS_ONE) |-> (y_filtered == OUT_MINUS_ONE))
        else $error("gate applied to one axis only");

endmodule
